@@ rtl/prex_pkg.sv @@
// Shared types, constants and codes for the printable run extractor.
package prex_pkg;

  localparam int HOLD_DEPTH = 8;
  localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int MIN_W      = 4;
  localparam int MAX_W      = 16;
  localparam int RUN_W      = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 16;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] PRINT_LOW    = 8'h20;
  localparam logic [7:0] PRINT_HIGH   = 8'h7E;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [MIN_W-1:0] MIN_RESET = 4'd4;
  localparam logic [MAX_W-1:0] MAX_RESET = 16'd4095;

  typedef enum logic {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last_of_item;
    logic             stream_done;
    logic [CNT_W-1:0] strings_found;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_STORE,
    JOB_EMIT,
    JOB_END
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [IDX_W-1:0] hold_idx;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] flush_cnt;
    logic             has_byte;
    logic             has_nl;
    logic [CNT_W-1:0] cnt_pre;
    logic [CNT_W-1:0] cnt_post;
  } job_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_FLUSH,
    PH_BYTE,
    PH_NL,
    PH_DONE
  } phase_t;

endpackage

@@ rtl/prex_front.sv @@
// Front end: configuration registers, run tracking and job generation.
module prex_front import prex_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  cfg_reg_t   cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  q_status_t  q_status,
  output logic       push,
  output job_t       push_job
);

  logic [MIN_W-1:0] min_length;
  logic [MAX_W-1:0] max_length;
  logic [RUN_W-1:0] run_length, run_length_next;
  logic             skip_byte, skip_byte_next;
  logic [CNT_W-1:0] string_count, string_count_next;

  logic [MIN_W-1:0] mn;
  logic [MAX_W-1:0] mx;
  logic [RUN_W-1:0] rl_inc;
  logic             printable;
  logic             accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    if (min_length == '0) begin
      mn = MIN_W'(1);
    end else if (32'(min_length) > HOLD_DEPTH) begin
      mn = MIN_W'(HOLD_DEPTH);
    end else begin
      mn = min_length;
    end
    mx        = (max_length == '0) ? MAX_W'(1) : max_length;
    rl_inc    = run_length + RUN_W'(1);
    printable = (in_data.data_byte >= PRINT_LOW) && (in_data.data_byte <= PRINT_HIGH);
  end

  always_comb begin
    push               = 1'b0;
    push_job.kind      = JOB_EMIT;
    push_job.hold_idx  = IDX_W'(run_length);
    push_job.data_byte = in_data.data_byte;
    push_job.flush_cnt = '0;
    push_job.has_byte  = 1'b0;
    push_job.has_nl    = 1'b0;
    push_job.cnt_pre   = string_count;
    push_job.cnt_post  = string_count;
    run_length_next    = run_length;
    skip_byte_next     = skip_byte;
    string_count_next  = string_count;
    if (accept) begin
      if (in_data.mode) begin
        push          = 1'b1;
        push_job.kind = JOB_END;
        if (run_length >= RUN_W'(mn)) begin
          push_job.has_nl   = 1'b1;
          push_job.cnt_post = string_count + CNT_W'(1);
        end
        run_length_next   = '0;
        skip_byte_next    = 1'b0;
        string_count_next = '0;
      end else if (skip_byte) begin
        skip_byte_next = 1'b0;
      end else if (printable) begin
        push            = 1'b1;
        run_length_next = rl_inc;
        if (rl_inc < RUN_W'(mn)) begin
          push_job.kind = JOB_STORE;
        end else if (rl_inc == RUN_W'(mn)) begin
          push_job.has_byte  = 1'b1;
          push_job.flush_cnt = IDX_W'(mn - MIN_W'(1));
        end else begin
          push_job.has_byte = 1'b1;
        end
        if (rl_inc >= RUN_W'(mx)) begin
          run_length_next = '0;
          skip_byte_next  = 1'b1;
          if (rl_inc >= RUN_W'(mn)) begin
            push_job.has_nl   = 1'b1;
            push_job.cnt_post = string_count + CNT_W'(1);
            string_count_next = string_count + CNT_W'(1);
          end
        end
      end else begin
        run_length_next = '0;
        if (run_length >= RUN_W'(mn)) begin
          push              = 1'b1;
          push_job.has_nl   = 1'b1;
          push_job.cnt_post = string_count + CNT_W'(1);
          string_count_next = string_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length   <= MIN_RESET;
      max_length   <= MAX_RESET;
      run_length   <= '0;
      skip_byte    <= 1'b0;
      string_count <= '0;
    end else begin
      run_length   <= run_length_next;
      skip_byte    <= skip_byte_next;
      string_count <= string_count_next;
      if (cfg_write_en) begin
        case (cfg_index)
          REG_MIN_LENGTH: min_length <= cfg_data[MIN_W-1:0];
          REG_MAX_LENGTH: max_length <= cfg_data[MAX_W-1:0];
          default:        min_length <= min_length;
        endcase
      end
    end
  end

endmodule

@@ rtl/prex_queue.sv @@
// Short job queue between the front end and the output sequencer.
module prex_queue import prex_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t q_status
);

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head_job            = mem[rd_ptr];
  assign q_status.head_valid = (count != '0);
  assign q_status.full       = (count == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/prex_back.sv @@
// Back end: held-byte store and output sequencer, one result per cycle unless the output stalls.
module prex_back import prex_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      head_job,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [7:0]       held [HOLD_DEPTH];
  phase_t           phase, phase_next;
  logic [IDX_W-1:0] fidx, fidx_next;
  phase_t           step;
  logic             can_load;
  logic             act;
  logic             finish;
  logic             emit;
  out_item_t        result;

  assign can_load = !out_valid || !out_stall;
  assign act      = q_status.head_valid && can_load;

  // Work out which result of the head job is due now.
  always_comb begin
    case (phase)
      PH_FIRST: begin
        if (head_job.flush_cnt != '0) begin
          step = PH_FLUSH;
        end else if (head_job.has_byte) begin
          step = PH_BYTE;
        end else if (head_job.has_nl) begin
          step = PH_NL;
        end else if (head_job.kind == JOB_END) begin
          step = PH_DONE;
        end else begin
          step = PH_FIRST;
        end
      end
      default: step = phase;
    endcase
  end

  always_comb begin
    phase_next = PH_FIRST;
    fidx_next  = '0;
    finish     = 1'b0;
    case (step)
      PH_FLUSH: begin
        if (fidx != head_job.flush_cnt - IDX_W'(1)) begin
          phase_next = PH_FLUSH;
          fidx_next  = fidx + IDX_W'(1);
        end else if (head_job.has_byte) begin
          phase_next = PH_BYTE;
        end else if (head_job.has_nl) begin
          phase_next = PH_NL;
        end else if (head_job.kind == JOB_END) begin
          phase_next = PH_DONE;
        end else begin
          finish = 1'b1;
        end
      end
      PH_BYTE: begin
        if (head_job.has_nl) begin
          phase_next = PH_NL;
        end else if (head_job.kind == JOB_END) begin
          phase_next = PH_DONE;
        end else begin
          finish = 1'b1;
        end
      end
      PH_NL: begin
        if (head_job.kind == JOB_END) begin
          phase_next = PH_DONE;
        end else begin
          finish = 1'b1;
        end
      end
      default: finish = 1'b1;
    endcase
  end

  always_comb begin
    result.out_byte      = 8'h00;
    result.byte_valid    = 1'b1;
    result.last_of_item  = finish;
    result.stream_done   = 1'b0;
    result.strings_found = head_job.cnt_pre;
    case (step)
      PH_FLUSH: result.out_byte = held[fidx];
      PH_BYTE:  result.out_byte = head_job.data_byte;
      PH_NL: begin
        result.out_byte      = NEWLINE_BYTE;
        result.strings_found = head_job.cnt_post;
      end
      PH_DONE: begin
        result.byte_valid    = 1'b0;
        result.stream_done   = 1'b1;
        result.strings_found = head_job.cnt_post;
      end
      default: result.byte_valid = 1'b0;
    endcase
  end

  assign emit = act && (step != PH_FIRST);
  assign pop  = act && finish;

  always_ff @(posedge clk) begin
    if (act && (head_job.kind == JOB_STORE)) begin
      held[head_job.hold_idx] <= head_job.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      fidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (act) begin
        phase <= phase_next;
        fidx  <= fidx_next;
      end
      if (can_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && emit) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/printable_run_extractor_core.sv @@
// Printable run extractor: top level joining front end, job queue and output sequencer.
// Path: with the sequencer idle, an accepted item's job is written into the queue, and its
//   first result is then registered into the output register.
// Throughput: one item per cycle while the queue is not full; a stored byte takes one
//   sequencer step, an item with k results k steps (up to nine when the held bytes of a
//   run flush), and a skipped or ignored byte none; the one output port sets this.
// Reset: synchronous rst clears run state, string count and queue and restores
//   min_length 4 and max_length 4095; the held-byte store is not cleared.
module printable_run_extractor_core import prex_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  // Jobs travel from the front end into the queue.
  logic      push;
  job_t      push_job;
  // Head of the queue feeds the sequencer; pop drops a finished job.
  logic      pop;
  job_t      head_job;
  q_status_t q_status;

  // Classify each byte, track run length and count, and stall only on a full queue.
  prex_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .q_status     (q_status),
    .push         (push),
    .push_job     (push_job)
  );

  // Decouple the two sides so a stalled output does not hold the input at once.
  prex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  // Store held bytes and expand each job into its results, one transfer per cycle unless the output stalls.
  prex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The end-of-stream result always closes its item.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stream_done) |-> out_data.last_of_item)
    else $error("stream_done result not marked last");

  // Only the end-of-stream result carries no byte.
  a_no_byte_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_valid) |-> out_data.stream_done)
    else $error("result without byte that is not end of stream");

  // A newline that ends the item right after an end-of-stream result reports a non-zero string count.
  a_newline_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.byte_valid && out_data.last_of_item &&
     (out_data.out_byte == NEWLINE_BYTE) && $past(out_valid && !out_stall)
     && $past(out_data.stream_done)) |-> (out_data.strings_found != '0))
    else $error("newline after stream restart with zero count");

endmodule
